// File: hdl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, defaults, the CORDIC angle table and the bundle that rides
// alongside the square-root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

	localparam int QW                  = 16;
	localparam int PROD_W              = 32;
	localparam int TERM_W              = 34;
	localparam int CW                  = 36;
	localparam int ZW                  = 34;
	localparam int TBL_FRAC            = 24;
	localparam int TBL_LEN             = 24;
	localparam int SQ_W                = 62;
	localparam int SQ_STEPS            = 31;
	localparam int ROOT_W              = 31;
	localparam int MAG_W               = 30;
	localparam int ROLL_W              = 16;
	localparam int PITCH_W             = 15;
	localparam int YAW_W               = 16;
	localparam int CORDIC_STAGES_DEF   = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 7;

	// 1.0 in Q2.30 at term width
	localparam logic signed [TERM_W-1:0] ONE_Q30 = TERM_W'(longint'(1) << 30);

	typedef struct packed {
		logic signed [TERM_W-1:0] sr;
		logic signed [TERM_W-1:0] cr;
		logic signed [TERM_W-1:0] sy;
		logic signed [TERM_W-1:0] cy;
		logic signed [TERM_W-1:0] py;
		logic                     psat;
	} side_t;

	// atan(2^-i) in degrees, 24 fraction bits
	function automatic logic [29:0] atan_tbl(input logic [4:0] idx);
		logic [29:0] t;
		case (idx)
			5'd0:    t = 30'd754974720;
			5'd1:    t = 30'd445687602;
			5'd2:    t = 30'd235489088;
			5'd3:    t = 30'd119537938;
			5'd4:    t = 30'd60000934;
			5'd5:    t = 30'd30029717;
			5'd6:    t = 30'd15018523;
			5'd7:    t = 30'd7509720;
			5'd8:    t = 30'd3754917;
			5'd9:    t = 30'd1877466;
			5'd10:   t = 30'd938734;
			5'd11:   t = 30'd469367;
			5'd12:   t = 30'd234684;
			5'd13:   t = 30'd117342;
			5'd14:   t = 30'd58671;
			5'd15:   t = 30'd29335;
			5'd16:   t = 30'd14668;
			5'd17:   t = 30'd7334;
			5'd18:   t = 30'd3667;
			5'd19:   t = 30'd1833;
			5'd20:   t = 30'd917;
			5'd21:   t = 30'd458;
			5'd22:   t = 30'd229;
			5'd23:   t = 30'd115;
			default: t = 30'd0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// File: hdl/q2e_terms.sv
// ----------------------------------------------------------------------------
// q2e_terms
// Product terms of the ZYX conversion, pitch saturation and the radicand
// 1 - s*s for the pitch cosine, in five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_terms import q2e_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_v,
	input  wire logic signed [QW-1:0]     x,
	input  wire logic signed [QW-1:0]     y,
	input  wire logic signed [QW-1:0]     z,
	input  wire logic signed [QW-1:0]     w,
	output logic                          out_v,
	output logic [SQ_W-1:0]               rad,
	output side_t                         side
);

	localparam logic [SQ_W-1:0] ONE_Q60 = SQ_W'(64'd1 << 60);

	logic signed [PROD_W-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	logic signed [TERM_W-1:0] sp_s2, sp_c;
	side_t                    side_s2, side_s3, side_s4, side_s5;
	logic [MAG_W-1:0]         mag_s3;
	logic [2*MAG_W-1:0]       sq_s4;
	logic [SQ_W-1:0]          rad_s5;
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign sp_c = (TERM_W'(wy_s1) - TERM_W'(zx_s1)) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= PROD_W'(w) * PROD_W'(x);
			yz_s1 <= PROD_W'(y) * PROD_W'(z);
			xx_s1 <= PROD_W'(x) * PROD_W'(x);
			yy_s1 <= PROD_W'(y) * PROD_W'(y);
			wy_s1 <= PROD_W'(w) * PROD_W'(y);
			zx_s1 <= PROD_W'(z) * PROD_W'(x);
			wz_s1 <= PROD_W'(w) * PROD_W'(z);
			xy_s1 <= PROD_W'(x) * PROD_W'(y);
			zz_s1 <= PROD_W'(z) * PROD_W'(z);

			side_s2.sr   <= (TERM_W'(wx_s1) + TERM_W'(yz_s1)) <<< 1;
			side_s2.cr   <= ONE_Q30 - ((TERM_W'(xx_s1) + TERM_W'(yy_s1)) <<< 1);
			side_s2.sy   <= (TERM_W'(wz_s1) + TERM_W'(xy_s1)) <<< 1;
			side_s2.cy   <= ONE_Q30 - ((TERM_W'(yy_s1) + TERM_W'(zz_s1)) <<< 1);
			side_s2.py   <= '0;
			side_s2.psat <= (sp_c >= ONE_Q30) || (sp_c <= -ONE_Q30);
			sp_s2        <= sp_c;

			// saturated pitch feeds the cordic a pure +-y vector
			side_s3.sr   <= side_s2.sr;
			side_s3.cr   <= side_s2.cr;
			side_s3.sy   <= side_s2.sy;
			side_s3.cy   <= side_s2.cy;
			side_s3.psat <= side_s2.psat;
			if (side_s2.psat) begin
				mag_s3     <= '0;
				side_s3.py <= sp_s2[TERM_W-1] ? -TERM_W'(1) : TERM_W'(1);
			end else begin
				mag_s3     <= sp_s2[TERM_W-1] ? MAG_W'(-sp_s2) : MAG_W'(sp_s2);
				side_s3.py <= sp_s2;
			end

			sq_s4   <= (2*MAG_W)'(mag_s3) * (2*MAG_W)'(mag_s3);
			side_s4 <= side_s3;

			rad_s5  <= ONE_Q60 - SQ_W'(sq_s4);
			side_s5 <= side_s4;
		end
	end

	assign out_v = v_s5;
	assign rad   = rad_s5;
	assign side  = side_s5;

endmodule

`default_nettype wire

// File: hdl/q2e_isqrt.sv
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined digit-by-digit integer square root, one result bit per stage;
// the term bundle travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_isqrt import q2e_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_v,
	input  wire logic [SQ_W-1:0]    rad,
	input  side_t                   side_in,
	output logic                    out_v,
	output logic [ROOT_W-1:0]       root,
	output side_t                   side_out
);

	logic [SQ_W-1:0] rem_s  [0:SQ_STEPS-1];
	logic [SQ_W-1:0] res_s  [0:SQ_STEPS-1];
	side_t           side_s [0:SQ_STEPS-1];
	logic            vld_s  [0:SQ_STEPS-1];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2*(SQ_STEPS-1-k));

		logic [SQ_W-1:0] rem_i, res_i, trial;
		logic            vld_i;
		side_t           side_i;

		if (k == 0) begin : g_first
			assign rem_i  = rad;
			assign res_i  = '0;
			assign vld_i  = in_v;
			assign side_i = side_in;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign res_i  = res_s[k-1];
			assign vld_i  = vld_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = res_i + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= trial) begin
					rem_s[k] <= rem_i - trial;
					res_s[k] <= (res_i >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_i;
					res_s[k] <= res_i >> 1;
				end
				side_s[k] <= side_i;
			end
		end
	end

	assign out_v    = vld_s[SQ_STEPS-1];
	assign root     = res_s[SQ_STEPS-1][ROOT_W-1:0];
	assign side_out = side_s[SQ_STEPS-1];

endmodule

`default_nettype wire

// File: hdl/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC atan2 in degrees: quadrant fold, one rotation
// per stage, then rounding and clamping to the output angle.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic import q2e_pkg::*; #(
	parameter int STAGES  = CORDIC_STAGES_DEF,
	parameter int AFB     = ANGLE_FRAC_BITS_DEF,
	parameter int LIM_DEG = 180,
	parameter int OUT_W   = ROLL_W
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_v,
	input  wire logic signed [TERM_W-1:0] y,
	input  wire logic signed [TERM_W-1:0] x,
	output logic                          out_v,
	output logic [OUT_W-1:0]              angle
);

	localparam int SH = TBL_FRAC - AFB;
	localparam logic signed [ZW-1:0] DEG180 = ZW'(longint'(180) << TBL_FRAC);
	localparam logic signed [ZW-1:0] DEG90  = ZW'(longint'(90) << TBL_FRAC);
	localparam logic signed [ZW-1:0] HALF   = ZW'(longint'(1) << (SH-1));
	localparam logic signed [ZW-1:0] LIM    = ZW'(longint'(LIM_DEG) << AFB);

	logic signed [CW-1:0] x_s [0:STAGES];
	logic signed [CW-1:0] y_s [0:STAGES];
	logic signed [ZW-1:0] z_s [0:STAGES];
	logic                 f_s [0:STAGES];
	logic                 v_s [0:STAGES];

	logic signed [CW-1:0] xi, yi;
	logic signed [ZW-1:0] zi, rnd;
	logic                 frz;
	logic [OUT_W-1:0]     ang_s;
	logic                 vo_s;

	// zero operands give a fixed angle and freeze the accumulator
	always_comb begin
		xi  = CW'(x);
		yi  = CW'(y);
		zi  = '0;
		frz = 1'b0;
		if (y == '0) begin
			frz = 1'b1;
			zi  = (x < 0) ? DEG180 : '0;
		end else if (x == '0) begin
			frz = 1'b1;
			zi  = (y > 0) ? DEG90 : -DEG90;
		end else if (x < 0) begin
			zi = (y > 0) ? DEG180 : -DEG180;
			xi = -CW'(x);
			yi = -CW'(y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= xi;
			y_s[0] <= yi;
			z_s[0] <= zi;
			f_s[0] <= frz;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam logic signed [ZW-1:0] ANG = ZW'(atan_tbl(5'(i)));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[i+1] <= f_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= f_s[i] ? z_s[i] : z_s[i] + ANG;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= f_s[i] ? z_s[i] : z_s[i] - ANG;
				end
			end
		end
	end

	// round half up, then clamp
	always_comb begin
		rnd = (z_s[STAGES] + HALF) >>> SH;
		if (rnd > LIM) begin
			rnd = LIM;
		end else if (rnd < -LIM) begin
			rnd = -LIM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_s <= 1'b0;
		end else if (en) begin
			vo_s <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s <= rnd[OUT_W-1:0];
		end
	end

	assign out_v = vo_s;
	assign angle = ang_s;

endmodule

`default_nettype wire

// File: hdl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion in Q1.15 to ZYX roll, pitch and yaw in fixed-point degrees.
// ----------------------------------------------------------------------------
// One quaternion is taken per clock while in_stall is low and passes
// 39 + CORDIC_STAGES register stages (55 with the default of 16) before its
// output transfer: product terms and radicand, the pipelined square root for
// the pitch cosine, then a fold stage, CORDIC_STAGES rotation stages and a
// rounding stage in three parallel atan2 lanes, and the output register. The
// whole pipeline advances together; while a result waits in the output
// register the pipeline keeps moving until the next result lands in a
// one-entry skid buffer, after which in_stall rises until the output is taken.
`default_nettype none

module quaternion_to_euler_angles import q2e_pkg::*; #(
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic signed [QW-1:0]  quat_x,
	input  wire logic signed [QW-1:0]  quat_y,
	input  wire logic signed [QW-1:0]  quat_z,
	input  wire logic signed [QW-1:0]  quat_w,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [ROLL_W-1:0]   roll_deg,
	output logic signed [PITCH_W-1:0]  pitch_deg,
	output logic signed [YAW_W-1:0]    yaw_deg
);

	logic                     en;
	logic                     t_v, s_v, r_v, p_v, w_v;
	logic [SQ_W-1:0]          rad;
	side_t                    t_side, s_side;
	logic [ROOT_W-1:0]        root;
	logic signed [TERM_W-1:0] px;
	logic [ROLL_W-1:0]        r_ang;
	logic [PITCH_W-1:0]       p_ang;
	logic [YAW_W-1:0]         w_ang;

	logic                     out_v_q, skid_v_q;
	logic [ROLL_W-1:0]        roll_q, roll_skid_q;
	logic [PITCH_W-1:0]       pitch_q, pitch_skid_q;
	logic [YAW_W-1:0]         yaw_q, yaw_skid_q;

	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	q2e_terms u_terms (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in_valid),
		.x      (quat_x),
		.y      (quat_y),
		.z      (quat_z),
		.w      (quat_w),
		.out_v  (t_v),
		.rad    (rad),
		.side   (t_side)
	);

	q2e_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (t_v),
		.rad      (rad),
		.side_in  (t_side),
		.out_v    (s_v),
		.root     (root),
		.side_out (s_side)
	);

	assign px = s_side.psat ? '0 : $signed(TERM_W'(root));

	q2e_cordic #(
		.STAGES  (CORDIC_STAGES),
		.AFB     (ANGLE_FRAC_BITS),
		.LIM_DEG (180),
		.OUT_W   (ROLL_W)
	) u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (s_v),
		.y      (s_side.sr),
		.x      (s_side.cr),
		.out_v  (r_v),
		.angle  (r_ang)
	);

	q2e_cordic #(
		.STAGES  (CORDIC_STAGES),
		.AFB     (ANGLE_FRAC_BITS),
		.LIM_DEG (90),
		.OUT_W   (PITCH_W)
	) u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (s_v),
		.y      (s_side.py),
		.x      (px),
		.out_v  (p_v),
		.angle  (p_ang)
	);

	q2e_cordic #(
		.STAGES  (CORDIC_STAGES),
		.AFB     (ANGLE_FRAC_BITS),
		.LIM_DEG (180),
		.OUT_W   (YAW_W)
	) u_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (s_v),
		.y      (s_side.sy),
		.x      (s_side.cy),
		.out_v  (w_v),
		.angle  (w_ang)
	);

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && out_stall) begin
			if (en && r_v) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= r_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && out_stall) begin
			if (en && r_v) begin
				roll_skid_q  <= r_ang;
				pitch_skid_q <= p_ang;
				yaw_skid_q   <= w_ang;
			end
		end else if (skid_v_q) begin
			roll_q  <= roll_skid_q;
			pitch_q <= pitch_skid_q;
			yaw_q   <= yaw_skid_q;
		end else begin
			roll_q  <= r_ang;
			pitch_q <= p_ang;
			yaw_q   <= w_ang;
		end
	end

	assign out_valid = out_v_q;
	assign roll_deg  = $signed(roll_q);
	assign pitch_deg = $signed(pitch_q);
	assign yaw_deg   = $signed(yaw_q);

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with no output pending");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && out_stall))
		else $error("skid entry filled while output was free");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_stall |=> out_v_q && !skid_v_q)
		else $error("skid entry not moved to output after transfer");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(p_v == r_v) && (w_v == r_v))
		else $error("angle lanes out of step");

endmodule

`default_nettype wire

// File: test/quaternion_to_euler_angles_check.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_check
// Watches both channels of the converter, works out roll, pitch and yaw for
// each accepted quaternion and compares every output transfer in order.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_check import q2e_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic signed [QW-1:0]      quat_x,
	input  logic signed [QW-1:0]      quat_y,
	input  logic signed [QW-1:0]      quat_z,
	input  logic signed [QW-1:0]      quat_w,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [ROLL_W-1:0]  roll_deg,
	input  logic signed [PITCH_W-1:0] pitch_deg,
	input  logic signed [YAW_W-1:0]   yaw_deg,
	output int                        fails,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int FRAC   = ANGLE_FRAC_BITS_DEF;
	localparam longint Q30 = longint'(1) << 30;

	typedef struct packed {
		logic signed [ROLL_W-1:0]  roll;
		logic signed [PITCH_W-1:0] pitch;
		logic signed [YAW_W-1:0]   yaw;
	} angles_t;

	angles_t angles_q[$];

	function automatic longint deg_scaled(input longint d);
		return d * (longint'(1) << TBL_FRAC);
	endfunction

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = longint'(1) << 62;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(input longint yv, input longint xv);
		longint off, acc, nx, ny;
		off = 0;
		acc = 0;
		if (yv == 0)
			return (xv < 0) ? deg_scaled(180) : 0;
		if (xv == 0)
			return (yv > 0) ? deg_scaled(90) : -deg_scaled(90);
		// fold left half plane into the right one
		if (xv < 0) begin
			off = (yv > 0) ? deg_scaled(180) : -deg_scaled(180);
			xv = -xv;
			yv = -yv;
		end
		for (int i = 0; i < STAGES && i < TBL_LEN; i++) begin
			if (yv > 0) begin
				nx = xv + (yv >>> i);
				ny = yv - (xv >>> i);
				acc = acc + longint'(atan_tbl(5'(i)));
			end else begin
				nx = xv - (yv >>> i);
				ny = yv + (xv >>> i);
				acc = acc - longint'(atan_tbl(5'(i)));
			end
			xv = nx;
			yv = ny;
		end
		return acc + off;
	endfunction

	function automatic longint round_deg(input longint a, input longint lim_deg);
		longint lim, r;
		lim = lim_deg * (longint'(1) << FRAC);
		r = (a + (longint'(1) << (TBL_FRAC - FRAC - 1))) >>> (TBL_FRAC - FRAC);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic angles_t euler_of(input longint x, input longint y,
			input longint z, input longint w);
		longint sr, cr, sp, sy, cy, p;
		longint unsigned c;
		angles_t e;
		sr = 2 * (w * x + y * z);
		cr = Q30 - 2 * (x * x + y * y);
		sp = 2 * (w * y - z * x);
		sy = 2 * (w * z + x * y);
		cy = Q30 - 2 * (y * y + z * z);
		e.roll = ROLL_W'(round_deg(vector_angle(sr, cr), 180));
		e.yaw = YAW_W'(round_deg(vector_angle(sy, cy), 180));
		if (sp >= Q30) begin
			p = 90 * (longint'(1) << FRAC);
		end else if (sp <= -Q30) begin
			p = -90 * (longint'(1) << FRAC);
		end else begin
			c = root64(longint'(Q30 * Q30 - sp * sp));
			p = round_deg(vector_angle(sp, longint'(c)), 90);
		end
		e.pitch = PITCH_W'(p);
		return e;
	endfunction

	assign pending = angles_q.size();

	always @(posedge clk) begin
		angles_t want;
		if (!arst_n) begin
			fails = 0;
		end else begin
			if (in_valid && !in_stall)
				angles_q = {angles_q, euler_of(quat_x, quat_y, quat_z, quat_w)};
			if (out_valid && !out_stall) begin
				if (angles_q.size() == 0) begin
					$display("%t: unexpected output transfer roll %0d pitch %0d yaw %0d",
						$time, roll_deg, pitch_deg, yaw_deg);
					fails++;
				end else begin
					want = angles_q.pop_front();
					if (roll_deg !== want.roll) begin
						$display("%t: roll expected %0d actual %0d", $time, want.roll, roll_deg);
						fails++;
					end
					if (pitch_deg !== want.pitch) begin
						$display("%t: pitch expected %0d actual %0d", $time, want.pitch,
							pitch_deg);
						fails++;
					end
					if (yaw_deg !== want.yaw) begin
						$display("%t: yaw expected %0d actual %0d", $time, want.yaw, yaw_deg);
						fails++;
					end
				end
			end
		end
	end
endmodule

// File: test/quaternion_to_euler_angles_test.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_test
// Drives directed and random quaternions in bursts against a stalling
// receiver and reports the checker's verdict.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_test import q2e_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1730;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [QW-1:0] quat_x = '0;
	logic signed [QW-1:0] quat_y = '0;
	logic signed [QW-1:0] quat_z = '0;
	logic signed [QW-1:0] quat_w = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ROLL_W-1:0] roll_deg;
	logic signed [PITCH_W-1:0] pitch_deg;
	logic signed [YAW_W-1:0] yaw_deg;
	int fails, pending;
	int gap_left = 0;

	always #4 clk = ~clk;

	quaternion_to_euler_angles DUT (.*);

	quaternion_to_euler_angles_check checker_i (.*);

	// one transfer; valid stays high into the next item when there is no gap
	task automatic send_quat(input logic [15:0] x, y, z, w);
		if (gap_left <= 0)
			gap_left = $urandom_range(1, 24);
		quat_x <= x;
		quat_y <= y;
		quat_z <= z;
		quat_w <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		gap_left--;
		if (gap_left == 0 && $urandom_range(0, 2) != 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
	endtask

	function automatic logic signed [15:0] unit_part(input real c, input real n);
		return 16'($rtoi(c / n * 32767.0));
	endfunction

	task automatic send_unit();
		real c[4];
		real n;
		n = 0.0;
		for (int i = 0; i < 4; i++) begin
			c[i] = real'($urandom_range(0, 65535)) / 32768.0 - 1.0;
			n = n + c[i] * c[i];
		end
		n = $sqrt(n);
		if (n < 0.01)
			send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
		else
			send_quat(unit_part(c[0], n), unit_part(c[1], n), unit_part(c[2], n),
				unit_part(c[3], n));
	endtask

	// receiver stall pattern: phases of free flow, light and heavy back-pressure
	initial begin
		int mode, span;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(32, 300);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		int sel;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
		send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768);
		send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
		send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
		send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0);
		send_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0);
		send_quat(16'sd0, 16'sd0, -16'sd32768, 16'sd0);
		// near gimbal lock both ways, pitch close to +-90 but short of saturation
		send_quat(16'sd0, 16'sd23170, 16'sd0, 16'sd23170);
		send_quat(16'sd0, -16'sd23170, 16'sd0, 16'sd23170);
		send_quat(16'sd23170, 16'sd0, 16'sd23170, -16'sd23170);
		send_quat(16'sd0, 16'sd23169, 16'sd0, 16'sd23169);
		// roll and yaw terms with a near-zero denominator, quarter turns both ways
		send_quat(16'sd23170, 16'sd0, 16'sd0, 16'sd23170);
		send_quat(-16'sd23170, 16'sd0, 16'sd0, 16'sd23170);
		send_quat(16'sd0, 16'sd0, 16'sd23170, 16'sd23170);
		send_quat(16'sd0, 16'sd0, 16'sd23170, -16'sd23170);
		// non-unit extremes
		send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
		send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
		send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
		send_quat(16'sd1, -16'sd1, 16'sd1, 16'sd32767);

		repeat (RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 70)
				send_unit();
			else if (sel < 90)
				send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			else if (sel < 95)
				send_quat(16'sd0, 16'($urandom_range(23160, 23180)), 16'sd0,
					16'($urandom_range(23160, 23180)));
			else
				send_quat(16'($urandom_range(0, 3)), -16'($urandom_range(0, 3)),
					16'($urandom_range(0, 3)), ($urandom_range(0, 1) != 0) ?
					16'sd32767 : -16'sd32768);
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#3ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
